// File: sv/wvb_pkg.sv
`default_nettype none

package wvb_pkg;

  localparam int IDX_W = 12;
  localparam int POS_W = 32;
  localparam int WGT_W = 18;
  localparam int PRD_W = POS_W + WGT_W;
  localparam int ACC_W = 64;
  localparam int EDG_W = POS_W + 1;
  localparam int CRS_W = 2 * EDG_W;
  localparam int DIF_W = CRS_W + 1;
  localparam int FRAC_SHIFT = 16;

  localparam logic [POS_W-1:0] SAT_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] SAT_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FuncWrite  = 2'd0,
    FuncHeader = 2'd1,
    FuncTerm   = 2'd2
  } func_e;

  typedef enum logic [4:0] {
    HdrIdle = 5'b00001,
    HdrRdB  = 5'b00010,
    HdrRdC  = 5'b00100,
    HdrEdge = 5'b01000,
    HdrMul  = 5'b10000
  } hdr_state_e;

  // element 0 is x, 1 is y, 2 is z
  typedef logic [2:0][POS_W-1:0] vtx_t;

  typedef struct packed {
    logic cap_a;
    logic cap_b;
    logic edge_en;
    logic mul_en;
    logic wr_en;
  } nrm_ctrl_t;

  // floor shift right by the fraction bits, then clamp to 32 bits
  function automatic logic [POS_W-1:0] shift_sat(input logic [DIF_W-1:0] v);
    logic [DIF_W-FRAC_SHIFT-1:0] s;
    logic                        all_one;
    logic                        all_zero;
    s        = v[DIF_W-1:FRAC_SHIFT];
    all_one  = &s[DIF_W-FRAC_SHIFT-1:POS_W-1];
    all_zero = ~(|s[DIF_W-FRAC_SHIFT-1:POS_W-1]);
    if (all_one || all_zero) begin
      return s[POS_W-1:0];
    end else if (s[DIF_W-FRAC_SHIFT-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/wvb_normal.sv
`default_nettype none

module wvb_normal (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire wvb_pkg::nrm_ctrl_t ctrl_i,
  input  wire wvb_pkg::vtx_t      vtx_i,
  output wvb_pkg::vtx_t      normal_o
);

  wvb_pkg::vtx_t a_q;
  wvb_pkg::vtx_t b_q;
  wvb_pkg::vtx_t nrm_q;

  logic signed [wvb_pkg::EDG_W-1:0] e1_q [3];
  logic signed [wvb_pkg::EDG_W-1:0] e2_q [3];
  logic signed [wvb_pkg::EDG_W-1:0] e1_d [3];
  logic signed [wvb_pkg::EDG_W-1:0] e2_d [3];
  logic signed [wvb_pkg::CRS_W-1:0] pa_q [3];
  logic signed [wvb_pkg::CRS_W-1:0] pb_q [3];
  logic signed [wvb_pkg::CRS_W-1:0] pa_d [3];
  logic signed [wvb_pkg::CRS_W-1:0] pb_d [3];
  logic signed [wvb_pkg::DIF_W-1:0] dif [3];

  // edges from corner a; vtx_i carries corner c in the edge step
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_d[i] = wvb_pkg::EDG_W'(signed'(b_q[i])) - wvb_pkg::EDG_W'(signed'(a_q[i]));
      e2_d[i] = wvb_pkg::EDG_W'(signed'(vtx_i[i])) - wvb_pkg::EDG_W'(signed'(a_q[i]));
    end
  end

  // (c - a) x (b - a)
  always_comb begin
    pa_d[0] = wvb_pkg::CRS_W'(e2_q[1]) * wvb_pkg::CRS_W'(e1_q[2]);
    pb_d[0] = wvb_pkg::CRS_W'(e2_q[2]) * wvb_pkg::CRS_W'(e1_q[1]);
    pa_d[1] = wvb_pkg::CRS_W'(e2_q[2]) * wvb_pkg::CRS_W'(e1_q[0]);
    pb_d[1] = wvb_pkg::CRS_W'(e2_q[0]) * wvb_pkg::CRS_W'(e1_q[2]);
    pa_d[2] = wvb_pkg::CRS_W'(e2_q[0]) * wvb_pkg::CRS_W'(e1_q[1]);
    pb_d[2] = wvb_pkg::CRS_W'(e2_q[1]) * wvb_pkg::CRS_W'(e1_q[0]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = wvb_pkg::DIF_W'(pa_q[i]) - wvb_pkg::DIF_W'(pb_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_a) begin
      a_q <= vtx_i;
    end
    if (ctrl_i.cap_b) begin
      b_q <= vtx_i;
    end
    if (ctrl_i.edge_en) begin
      e1_q <= e1_d;
      e2_q <= e2_d;
    end
    if (ctrl_i.mul_en) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q <= '0;
    end else if (ctrl_i.wr_en) begin
      for (int i = 0; i < 3; i++) begin
        nrm_q[i] <= wvb_pkg::shift_sat(dif[i]);
      end
    end
  end

  assign normal_o = nrm_q;

endmodule

`default_nettype wire

// File: sv/weighted_vertex_blend_with_face_normal.sv
`default_nettype none

// channel   direction  handshake                  payload
// input     in         in_valid_i / in_stall_o    func, vertex_index, corners, pos_x/y/z,
//                                                 term_weight, last_term
// output    out        out_valid_o / out_stall_i  vert_x/y/z, norm_x/y/z
//
// vertex writes and dependency terms: one per cycle while input is not stalled; a result
// goes from its last term through the read and product registers to the output register.
// a patch header stalls input in states RdB, RdC, Edge, Mul: corners b and c come through
// the one read port, then the edge and cross-product stages run before the normal updates.
// reset clears accumulators, normal and control; vertex memory is not cleared.
// input stalls while a last term waits behind a full output register held by out_stall_i.

module weighted_vertex_blend_with_face_normal #(
  parameter int CONTROL_VERTICES = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [wvb_pkg::IDX_W-1:0]     vertex_index_i,
  input  wire logic [wvb_pkg::IDX_W-1:0]     corner_a_i,
  input  wire logic [wvb_pkg::IDX_W-1:0]     corner_b_i,
  input  wire logic [wvb_pkg::IDX_W-1:0]     corner_c_i,
  input  wire logic signed [wvb_pkg::POS_W-1:0] pos_x_i,
  input  wire logic signed [wvb_pkg::POS_W-1:0] pos_y_i,
  input  wire logic signed [wvb_pkg::POS_W-1:0] pos_z_i,
  input  wire logic signed [wvb_pkg::WGT_W-1:0] term_weight_i,
  input  wire logic                          last_term_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic signed [wvb_pkg::POS_W-1:0] vert_x_o,
  output      logic signed [wvb_pkg::POS_W-1:0] vert_y_o,
  output      logic signed [wvb_pkg::POS_W-1:0] vert_z_o,
  output      logic signed [wvb_pkg::POS_W-1:0] norm_x_o,
  output      logic signed [wvb_pkg::POS_W-1:0] norm_y_o,
  output      logic signed [wvb_pkg::POS_W-1:0] norm_z_o
);

  localparam int AddrW = (CONTROL_VERTICES > 1) ? $clog2(CONTROL_VERTICES) : 1;
  localparam int CmpW  = 17;

  function automatic logic [AddrW-1:0] to_addr(input logic [wvb_pkg::IDX_W-1:0] idx);
    logic [AddrW+wvb_pkg::IDX_W-1:0] ext;
    ext = {{AddrW{1'b0}}, idx};
    return ext[AddrW-1:0];
  endfunction

  function automatic logic in_range(input logic [wvb_pkg::IDX_W-1:0] idx);
    return CmpW'(idx) < CmpW'(CONTROL_VERTICES);
  endfunction

  wvb_pkg::vtx_t mem [CONTROL_VERTICES];

  wvb_pkg::hdr_state_e hdr_q, hdr_d;
  logic [wvb_pkg::IDX_W-1:0] cb_q, cc_q;

  logic                      in_acc, is_term, is_hdr, hold;
  logic                      wr_en, rd_en;
  logic [AddrW-1:0]          rd_addr;
  logic [wvb_pkg::IDX_W-1:0] rd_idx;
  wvb_pkg::vtx_t             rd_q, vtx_rd;
  logic                      rd_ok_q;

  logic                              s1_v_q, s1_last_q;
  logic signed [wvb_pkg::WGT_W-1:0]  s1_w_q;
  logic                              s2_v_q, s2_last_q;
  logic signed [wvb_pkg::PRD_W-1:0]  prod_q [3];
  logic signed [wvb_pkg::PRD_W-1:0]  prod_d [3];
  logic signed [wvb_pkg::ACC_W-1:0]  acc_q [3];
  logic signed [wvb_pkg::ACC_W-1:0]  acc_sum [3];
  logic                              s2_fire;

  logic               out_v_q;
  wvb_pkg::vtx_t      out_vert_q, out_nrm_q, normal;
  wvb_pkg::nrm_ctrl_t nctl;
  logic               nv_q;

  assign is_term    = func_i == wvb_pkg::FuncTerm;
  assign is_hdr     = func_i == wvb_pkg::FuncHeader;
  assign hold       = s2_v_q & s2_last_q & out_v_q & out_stall_i;
  assign in_stall_o = hold | (hdr_q != wvb_pkg::HdrIdle);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign wr_en      = in_acc & (func_i == wvb_pkg::FuncWrite) & in_range(vertex_index_i);

  // one read port: terms and corner a at transfer, corners b and c afterwards
  always_comb begin
    rd_en  = 1'b0;
    rd_idx = vertex_index_i;
    case (hdr_q)
      wvb_pkg::HdrIdle: begin
        rd_en  = in_acc & (is_term | is_hdr);
        rd_idx = is_hdr ? corner_a_i : vertex_index_i;
      end
      wvb_pkg::HdrRdB: begin
        rd_en  = ~hold;
        rd_idx = cb_q;
      end
      wvb_pkg::HdrRdC: begin
        rd_en  = ~hold;
        rd_idx = cc_q;
      end
      default: begin
        rd_en  = 1'b0;
        rd_idx = vertex_index_i;
      end
    endcase
  end

  assign rd_addr = to_addr(rd_idx);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[to_addr(vertex_index_i)] <= {pos_z_i, pos_y_i, pos_x_i};
    end
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_ok_q <= in_range(rd_idx);
    end
  end

  assign vtx_rd = rd_ok_q ? rd_q : '0;

  always_comb begin
    hdr_d = hdr_q;
    if (!hold) begin
      case (hdr_q)
        wvb_pkg::HdrIdle: if (in_acc && is_hdr) hdr_d = wvb_pkg::HdrRdB;
        wvb_pkg::HdrRdB:  hdr_d = wvb_pkg::HdrRdC;
        wvb_pkg::HdrRdC:  hdr_d = wvb_pkg::HdrEdge;
        wvb_pkg::HdrEdge: hdr_d = wvb_pkg::HdrMul;
        wvb_pkg::HdrMul:  hdr_d = wvb_pkg::HdrIdle;
        default:          hdr_d = wvb_pkg::HdrIdle;
      endcase
    end
  end

  always_comb begin
    nctl.cap_a   = (hdr_q == wvb_pkg::HdrRdB) & ~hold;
    nctl.cap_b   = (hdr_q == wvb_pkg::HdrRdC) & ~hold;
    nctl.edge_en = (hdr_q == wvb_pkg::HdrEdge) & ~hold;
    nctl.mul_en  = (hdr_q == wvb_pkg::HdrMul) & ~hold;
    nctl.wr_en   = nv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= wvb_pkg::HdrIdle;
      nv_q  <= 1'b0;
    end else begin
      hdr_q <= hdr_d;
      nv_q  <= nctl.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_hdr) begin
      cb_q <= corner_b_i;
      cc_q <= corner_c_i;
    end
  end

  wvb_normal u_normal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (nctl),
    .vtx_i    (vtx_rd),
    .normal_o (normal)
  );

  // weight multiply
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = wvb_pkg::PRD_W'(signed'(vtx_rd[i])) * wvb_pkg::PRD_W'(s1_w_q);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_sum[i] = acc_q[i] + wvb_pkg::ACC_W'(prod_q[i]);
    end
  end

  assign s2_fire = s2_v_q & ~hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (!hold) begin
      s1_v_q <= in_acc & is_term;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold) begin
      s1_last_q <= last_term_i;
      s1_w_q    <= term_weight_i;
      s2_last_q <= s1_last_q;
      prod_q    <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= '0;
      end
    end else if (s2_fire) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= s2_last_q ? '0 : acc_sum[i];
      end
    end
  end

  // output register, reloaded in the cycle of its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_fire && s2_last_q) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && s2_last_q) begin
      for (int i = 0; i < 3; i++) begin
        out_vert_q[i] <= wvb_pkg::shift_sat(wvb_pkg::DIF_W'(acc_sum[i]));
      end
      out_nrm_q <= normal;
    end
  end

  assign out_valid_o = out_v_q;
  assign vert_x_o    = out_vert_q[0];
  assign vert_y_o    = out_vert_q[1];
  assign vert_z_o    = out_vert_q[2];
  assign norm_x_o    = out_nrm_q[0];
  assign norm_y_o    = out_nrm_q[1];
  assign norm_z_o    = out_nrm_q[2];

  // the read port belongs to the header while it fetches corners
  a_hdr_no_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_q != wvb_pkg::HdrIdle) |-> !s1_v_q)
    else $error("term in read stage during header fetch");

  // no blend in flight may see a normal from a later header
  a_nrm_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nv_q |-> !s2_v_q && !s1_v_q)
    else $error("normal updated with a term in flight");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && s2_last_q) |=> (acc_q[0] == '0) && (acc_q[1] == '0) && (acc_q[2] == '0))
    else $error("accumulators not cleared after last term");

  a_hdr_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_hdr) |=> in_stall_o ##1 in_stall_o)
    else $error("input taken while header corners are fetched");

endmodule

`default_nettype wire

// File: tb/weighted_vertex_blend_with_face_normal_test.sv
module weighted_vertex_blend_with_face_normal_test;

  localparam int VERTS = 4096;
  localparam int ITEMS = 700;
  localparam int REPORT_LIMIT = 100;
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam logic [wvb_pkg::IDX_W-1:0] LAST_IDX = wvb_pkg::IDX_W'(VERTS - 1);

  localparam logic signed [wvb_pkg::WGT_W-1:0] W_MAX = {1'b0, {(wvb_pkg::WGT_W-1){1'b1}}};
  localparam logic signed [wvb_pkg::WGT_W-1:0] W_MIN = {1'b1, {(wvb_pkg::WGT_W-1){1'b0}}};
  localparam logic signed [wvb_pkg::WGT_W-1:0] W_ONE = 18'sh10000;

  typedef struct {
    logic [1:0]                       func;
    logic [wvb_pkg::IDX_W-1:0]        vidx, ca, cb, cc;
    logic signed [wvb_pkg::POS_W-1:0] px, py, pz;
    logic signed [wvb_pkg::WGT_W-1:0] wgt;
    logic                             last;
  } blend_op_t;

  typedef struct {
    logic [wvb_pkg::POS_W-1:0] vx, vy, vz, nx, ny, nz;
  } blend_vertex_t;

  class blend_predictor;
    logic [2:0][wvb_pkg::POS_W-1:0] cv_mem [VERTS];
    logic [wvb_pkg::ACC_W-1:0]      acc [3];
    logic [wvb_pkg::POS_W-1:0]      nrm [3];
    blend_vertex_t                  expected_verts [$];
    int                             errors;

    function new();
      foreach (acc[i]) acc[i] = '0;
      foreach (nrm[i]) nrm[i] = '0;
      errors = 0;
    endfunction

    // floor shift to q16.16, clamp to 32 bits
    function logic [wvb_pkg::POS_W-1:0] floor_sat(input logic signed [127:0] v);
      logic signed [127:0] s;
      s = v >>> wvb_pkg::FRAC_SHIFT;
      if (&s[127:wvb_pkg::POS_W-1] || !(|s[127:wvb_pkg::POS_W-1]))
        return s[wvb_pkg::POS_W-1:0];
      return s[127] ? wvb_pkg::SAT_MIN : wvb_pkg::SAT_MAX;
    endfunction

    function void take_op(input blend_op_t op);
      logic signed [127:0] a [3], b [3], c [3], e1 [3], e2 [3];
      logic signed [63:0]  prod;
      blend_vertex_t       res;
      case (op.func)
        wvb_pkg::FuncWrite: cv_mem[op.vidx] = {op.pz, op.py, op.px};
        wvb_pkg::FuncHeader: begin
          for (int i = 0; i < 3; i++) begin
            a[i]  = $signed(cv_mem[op.ca][i]);
            b[i]  = $signed(cv_mem[op.cb][i]);
            c[i]  = $signed(cv_mem[op.cc][i]);
            e1[i] = b[i] - a[i];
            e2[i] = c[i] - a[i];
          end
          // (c - a) x (b - a), only the first three corners matter
          nrm[0] = floor_sat(e2[1] * e1[2] - e2[2] * e1[1]);
          nrm[1] = floor_sat(e2[2] * e1[0] - e2[0] * e1[2]);
          nrm[2] = floor_sat(e2[0] * e1[1] - e2[1] * e1[0]);
        end
        wvb_pkg::FuncTerm: begin
          for (int i = 0; i < 3; i++) begin
            prod   = $signed(cv_mem[op.vidx][i]) * op.wgt;
            acc[i] = acc[i] + prod;
          end
          if (op.last) begin
            res.vx = floor_sat($signed(acc[0]));
            res.vy = floor_sat($signed(acc[1]));
            res.vz = floor_sat($signed(acc[2]));
            res.nx = nrm[0];
            res.ny = nrm[1];
            res.nz = nrm[2];
            expected_verts.push_back(res);
            foreach (acc[i]) acc[i] = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void report(input string what, input logic [wvb_pkg::POS_W-1:0] want,
                         input logic [wvb_pkg::POS_W-1:0] got);
      errors++;
      if (errors <= REPORT_LIMIT)
        $error("%s: expected %0d, actual %0d", what, $signed(want), $signed(got));
    endfunction

    function void check_vertex(input blend_vertex_t got);
      blend_vertex_t want;
      if (expected_verts.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $error("result with nothing expected: vert %0d %0d %0d",
                 $signed(got.vx), $signed(got.vy), $signed(got.vz));
        return;
      end
      want = expected_verts.pop_front();
      if (got.vx !== want.vx) report("vert_x", want.vx, got.vx);
      if (got.vy !== want.vy) report("vert_y", want.vy, got.vy);
      if (got.vz !== want.vz) report("vert_z", want.vz, got.vz);
      if (got.nx !== want.nx) report("norm_x", want.nx, got.nx);
      if (got.ny !== want.ny) report("norm_y", want.ny, got.ny);
      if (got.nz !== want.nz) report("norm_z", want.nz, got.nz);
    endfunction

    function int pending();
      return expected_verts.size();
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic [1:0]                       func_i;
  logic [wvb_pkg::IDX_W-1:0]        vertex_index_i;
  logic [wvb_pkg::IDX_W-1:0]        corner_a_i;
  logic [wvb_pkg::IDX_W-1:0]        corner_b_i;
  logic [wvb_pkg::IDX_W-1:0]        corner_c_i;
  logic signed [wvb_pkg::POS_W-1:0] pos_x_i;
  logic signed [wvb_pkg::POS_W-1:0] pos_y_i;
  logic signed [wvb_pkg::POS_W-1:0] pos_z_i;
  logic signed [wvb_pkg::WGT_W-1:0] term_weight_i;
  logic                             last_term_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic signed [wvb_pkg::POS_W-1:0] vert_x_o;
  logic signed [wvb_pkg::POS_W-1:0] vert_y_o;
  logic signed [wvb_pkg::POS_W-1:0] vert_z_o;
  logic signed [wvb_pkg::POS_W-1:0] norm_x_o;
  logic signed [wvb_pkg::POS_W-1:0] norm_y_o;
  logic signed [wvb_pkg::POS_W-1:0] norm_z_o;

  blend_predictor            blend_pred;
  int unsigned               ops_sent;
  bit                        is_written [VERTS];
  logic [wvb_pkg::IDX_W-1:0] written_idx [$];
  bit                        hold_req;

  weighted_vertex_blend_with_face_normal u_top (.*);

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [wvb_pkg::POS_W-1:0] rand_pos();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return wvb_pkg::SAT_MAX;
      1: return wvb_pkg::SAT_MIN;
      2: return {{(wvb_pkg::POS_W-18){r[17]}}, r[17:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic signed [wvb_pkg::WGT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return W_MAX;
      1: return W_MIN;
      2: return W_ONE;
      default: return wvb_pkg::WGT_W'($urandom);
    endcase
  endfunction

  function automatic logic [wvb_pkg::IDX_W-1:0] rand_index();
    // a small pool so vertices get rewritten and reread
    if ($urandom_range(0, 1)) return wvb_pkg::IDX_W'($urandom_range(0, 63));
    return wvb_pkg::IDX_W'($urandom_range(0, VERTS - 1));
  endfunction

  function automatic logic [wvb_pkg::IDX_W-1:0] pick_written();
    return written_idx[$urandom_range(0, written_idx.size() - 1)];
  endfunction

  function automatic blend_op_t base_op();
    blend_op_t op;
    op.func = FuncUnused;
    op.vidx = wvb_pkg::IDX_W'($urandom);
    op.ca   = wvb_pkg::IDX_W'($urandom);
    op.cb   = wvb_pkg::IDX_W'($urandom);
    op.cc   = wvb_pkg::IDX_W'($urandom);
    op.px   = $urandom;
    op.py   = $urandom;
    op.pz   = $urandom;
    op.wgt  = wvb_pkg::WGT_W'($urandom);
    op.last = 1'($urandom_range(0, 1));
    return op;
  endfunction

  // entered and left at a falling edge
  task automatic offer_op(input blend_op_t op);
    int unsigned pick, gap;
    pick = $urandom_range(0, 99);
    gap  = (pick < 60) ? 0 : (pick < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i         <= op.func;
    vertex_index_i <= op.vidx;
    corner_a_i     <= op.ca;
    corner_b_i     <= op.cb;
    corner_c_i     <= op.cc;
    pos_x_i        <= op.px;
    pos_y_i        <= op.py;
    pos_z_i        <= op.pz;
    term_weight_i  <= op.wgt;
    last_term_i    <= op.last;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    blend_pred.take_op(op);
    if (op.func != FuncUnused) ops_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_vertex(input logic [wvb_pkg::IDX_W-1:0] idx,
                              input logic signed [wvb_pkg::POS_W-1:0] x,
                              input logic signed [wvb_pkg::POS_W-1:0] y,
                              input logic signed [wvb_pkg::POS_W-1:0] z, input logic last);
    blend_op_t op;
    op      = base_op();
    op.func = wvb_pkg::FuncWrite;
    op.vidx = idx;
    op.px   = x;
    op.py   = y;
    op.pz   = z;
    op.last = last;
    if (!is_written[idx]) begin
      is_written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
    offer_op(op);
  endtask

  task automatic patch_header(input logic [wvb_pkg::IDX_W-1:0] a,
                              input logic [wvb_pkg::IDX_W-1:0] b,
                              input logic [wvb_pkg::IDX_W-1:0] c, input logic last);
    blend_op_t op;
    op      = base_op();
    op.func = wvb_pkg::FuncHeader;
    op.ca   = a;
    op.cb   = b;
    op.cc   = c;
    op.last = last;
    offer_op(op);
  endtask

  task automatic blend_term(input logic [wvb_pkg::IDX_W-1:0] idx,
                            input logic signed [wvb_pkg::WGT_W-1:0] w, input logic last);
    blend_op_t op;
    op      = base_op();
    op.func = wvb_pkg::FuncTerm;
    op.vidx = idx;
    op.wgt  = w;
    op.last = last;
    offer_op(op);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (blend_pred.pending() != 0);
  endtask

  initial begin : result_monitor
    blend_vertex_t got;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        got.vx = vert_x_o;
        got.vy = vert_y_o;
        got.vz = vert_z_o;
        got.nx = norm_x_o;
        got.ny = norm_y_o;
        got.nz = norm_z_o;
        blend_pred.check_vertex(got);
      end
    end
  end

  initial begin : result_sink
    int unsigned pick, span;
    bit          level;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        // long hold-off so the blend pipe backs up into the input
        hold_req = 1'b0;
        level    = 1'b1;
        span     = 300;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          level = 1'b0;
          span  = $urandom_range(1, 24);
        end else if (pick < 96) begin
          level = 1'($urandom_range(0, 1));
          span  = $urandom_range(1, 3);
        end else begin
          level = 1'b1;
          span  = $urandom_range(20, 80);
        end
      end
      out_stall_i <= level;
      repeat (span) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned pick, n;
    bit          paused;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = '0;
    vertex_index_i = '0;
    corner_a_i     = '0;
    corner_b_i     = '0;
    corner_c_i     = '0;
    pos_x_i        = '0;
    pos_y_i        = '0;
    pos_z_i        = '0;
    term_weight_i  = '0;
    last_term_i    = 1'b0;
    ops_sent       = 0;
    hold_req       = 1'b0;
    paused         = 1'b0;
    blend_pred     = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes of the vertex fields; last mark on a write is ignored
    write_vertex(0, wvb_pkg::SAT_MAX, wvb_pkg::SAT_MAX, wvb_pkg::SAT_MAX, 1'b1);
    write_vertex(LAST_IDX, wvb_pkg::SAT_MIN, wvb_pkg::SAT_MIN, wvb_pkg::SAT_MIN, 1'b0);
    write_vertex(1, 32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000, 1'b0);
    write_vertex(2, '0, '0, '0, 1'b0);
    write_vertex(3, 32'sh1234_5678, wvb_pkg::SAT_MIN, wvb_pkg::SAT_MAX, 1'b0);
    // single-term blends, normal still at reset, saturation both ways
    blend_term(0, W_MAX, 1'b1);
    blend_term(LAST_IDX, W_MIN, 1'b1);
    blend_term(0, W_MIN, 1'b1);
    blend_term(1, '0, 1'b1);
    // header with extreme edges, last mark ignored
    patch_header(0, LAST_IDX, 1, 1'b1);
    blend_term(1, W_ONE, 1'b0);
    blend_term(3, -18'sd32768, 1'b0);
    blend_term(2, 18'sd5, 1'b0);
    blend_term(1, -18'sd1, 1'b1);
    offer_op(base_op());
    patch_header(3, 1, 2, 1'b0);
    blend_term(3, W_MAX, 1'b0);
    blend_term(3, W_MAX, 1'b0);
    blend_term(3, 18'sd1, 1'b1);
    // degenerate patch gives a zero normal
    patch_header(1, 1, 1, 1'b0);
    blend_term(LAST_IDX, W_MIN, 1'b0);
    blend_term(LAST_IDX, W_MIN, 1'b1);
    patch_header(LAST_IDX, 0, 0, 1'b0);
    // read right after write
    write_vertex(1, 32'sh7654_3210, -32'sh0000_0001, 32'sh0000_8000, 1'b0);
    blend_term(1, W_ONE, 1'b1);

    hold_req = 1'b1;
    while (ops_sent < ITEMS) begin
      if (!paused && ops_sent >= ITEMS / 2) begin
        paused = 1'b1;
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        n = $urandom_range(1, 4);
        repeat (n) write_vertex(rand_index(), rand_pos(), rand_pos(), rand_pos(), 1'b0);
      end else if (pick < 20) begin
        patch_header(pick_written(), pick_written(), pick_written(), 1'b0);
      end else if (pick < 85) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) blend_term(pick_written(), rand_weight(), k == n - 1);
      end else if (pick < 91) begin
        offer_op(base_op());
      end else if (pick < 96) begin
        if (pick[0]) write_vertex(rand_index(), rand_pos(), rand_pos(), rand_pos(), 1'b1);
        else patch_header(pick_written(), pick_written(), pick_written(), 1'b1);
      end else begin
        // a blend interrupted by a header and a write
        blend_term(pick_written(), rand_weight(), 1'b0);
        patch_header(pick_written(), pick_written(), pick_written(), 1'b0);
        write_vertex(rand_index(), rand_pos(), rand_pos(), rand_pos(), 1'b0);
        blend_term(pick_written(), rand_weight(), 1'b1);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (blend_pred.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
sv/wvb_pkg.sv
sv/wvb_normal.sv
sv/weighted_vertex_blend_with_face_normal.sv
tb/weighted_vertex_blend_with_face_normal_test.sv
